>>> rtl/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared constants and types for the learning switch forwarding table.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int MAX_PORTS     = 8;

  localparam int PORT_W  = 3;
  localparam int HOST_W  = 8;
  localparam int MASK_W  = 8;
  localparam int NPORT_W = 4;

  localparam logic [NPORT_W-1:0] NUM_PORTS_RST = NPORT_W'(MAX_PORTS);

  // lookup word travelling down the cell row
  typedef struct packed {
    logic              vld;
    logic [PORT_W-1:0] arrival_port;
    logic [HOST_W-1:0] source_host;
    logic [HOST_W-1:0] dest_host;
    logic              hit;
    logic [PORT_W-1:0] hit_port;
    logic              src_known;
    logic              learned;
  } lsf_word_t;

endpackage

>>> rtl/lsf_if.sv
// ----------------------------------------------------------------------------
// lsf_if
// Valid/ready channels for packet headers and forwarding results.
// ----------------------------------------------------------------------------
interface lsf_hdr_if;
  logic                      valid;
  logic                      ready;
  logic [lsf_pkg::PORT_W-1:0] arrival_port;
  logic [lsf_pkg::HOST_W-1:0] source_host;
  logic [lsf_pkg::HOST_W-1:0] dest_host;

  modport source (output valid, output arrival_port, output source_host,
                  output dest_host, input ready);
  modport sink   (input valid, input arrival_port, input source_host,
                  input dest_host, output ready);
endinterface

interface lsf_res_if;
  logic                      valid;
  logic                      ready;
  logic [lsf_pkg::MASK_W-1:0] send_mask;
  logic                      flooded;
  logic                      learned;
  logic                      table_full;

  modport source (output valid, output send_mask, output flooded,
                  output learned, output table_full, input ready);
  modport sink   (input valid, input send_mask, input flooded,
                  input learned, input table_full, output ready);
endinterface

>>> rtl/lsf_cell.sv
// ----------------------------------------------------------------------------
// lsf_cell
// One table entry plus one stage of the lookup word pipeline. Compares the
// passing word against its entry and claims itself for a new source when
// it is the first free entry.
// ----------------------------------------------------------------------------
module lsf_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  lsf_pkg::lsf_word_t word_i,
  output lsf_pkg::lsf_word_t word_o
);

  logic                       valid_q;
  logic [lsf_pkg::HOST_W-1:0] host_q;
  logic [lsf_pkg::PORT_W-1:0] port_q;
  lsf_pkg::lsf_word_t         word_q, word_d;

  logic match_dst, match_src, do_learn;

  assign match_dst = valid_q && (host_q == word_i.dest_host);
  assign match_src = valid_q && (host_q == word_i.source_host);
  assign do_learn  = word_i.vld && !valid_q && !word_i.src_known && !word_i.learned;

  always_comb begin
    word_d = word_i;
    if (match_dst) begin
      word_d.hit      = 1'b1;
      word_d.hit_port = port_q;
    end
    if (match_src) begin
      word_d.src_known = 1'b1;
    end
    if (do_learn) begin
      word_d.learned = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      word_q  <= '0;
    end else if (adv_i) begin
      word_q <= word_d;
      if (do_learn) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && do_learn) begin
      host_q <= word_i.source_host;
      port_q <= word_i.arrival_port;
    end
  end

  assign word_o = word_q;

`ifndef SYNTHESIS
  a_valid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> valid_q)
    else $error("entry valid bit dropped");

  a_learn_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_q) |-> (word_q.vld && word_q.learned
                        && host_q == word_q.source_host
                        && port_q == word_q.arrival_port))
    else $error("entry claimed without matching word");

  a_learn_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_q.vld |-> !(word_q.src_known && word_q.learned))
    else $error("known source learned again");
`endif

endmodule

>>> rtl/lsf_result.sv
// ----------------------------------------------------------------------------
// lsf_result
// Output stage: builds the send mask from the finished lookup word and
// holds the result until it is taken. Drives the row advance.
// ----------------------------------------------------------------------------
module lsf_result (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lsf_pkg::lsf_word_t          word_i,
  input  logic [lsf_pkg::NPORT_W-1:0] num_ports_i,
  output logic                        adv_o,
  lsf_res_if.source                   res_o
);

  logic                        vld_q;
  logic [lsf_pkg::MASK_W-1:0]  mask_q, mask_d;
  logic                        flooded_q, learned_q, full_q;
  logic [lsf_pkg::NPORT_W-1:0] in_use;
  logic [lsf_pkg::MASK_W-1:0]  flood_mask;

  assign adv_o  = !vld_q || res_o.ready;
  assign in_use = (num_ports_i > lsf_pkg::NPORT_W'(lsf_pkg::MAX_PORTS))
                  ? lsf_pkg::NPORT_W'(lsf_pkg::MAX_PORTS) : num_ports_i;

  always_comb begin
    for (int p = 0; p < lsf_pkg::MASK_W; p++) begin
      flood_mask[p] = (lsf_pkg::NPORT_W'(p) < in_use)
                      && (lsf_pkg::PORT_W'(p) != word_i.arrival_port);
    end
    if (!word_i.hit) begin
      mask_d = flood_mask;
    end else if ({1'b0, word_i.hit_port} < in_use) begin
      mask_d = lsf_pkg::MASK_W'(1) << word_i.hit_port;
    end else begin
      mask_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_o) begin
      vld_q <= word_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      mask_q    <= mask_d;
      flooded_q <= !word_i.hit;
      learned_q <= word_i.learned;
      full_q    <= !word_i.src_known && !word_i.learned;
    end
  end

  assign res_o.valid      = vld_q;
  assign res_o.send_mask  = mask_q;
  assign res_o.flooded    = flooded_q;
  assign res_o.learned    = learned_q;
  assign res_o.table_full = full_q;

`ifndef SYNTHESIS
  a_learn_xor_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> !(learned_q && full_q))
    else $error("learned and table full together");
`endif

endmodule

>>> rtl/learning_switch_forwarding.sv
// Path: a header word passes through every entry cell in turn, then the result register.
// Throughput: one header word per cycle while results are taken; the row of entry cells is a
// pipeline, so a word sees every entry learned by the words ahead of it.
// A stalled result word freezes the whole row.
// Reset: all entries invalid, num_ports = 8; no clearing pass needed.
// ----------------------------------------------------------------------------
// learning_switch_forwarding
// Learning switch forwarding table built as a row of entry cells.
// ----------------------------------------------------------------------------
module learning_switch_forwarding (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lsf_pkg::NPORT_W-1:0] cfg_wdata_i,
  lsf_hdr_if.sink                     hdr_i,
  lsf_res_if.source                   res_o
);

  logic                        adv;
  logic [lsf_pkg::NPORT_W-1:0] num_ports_q;
  lsf_pkg::lsf_word_t          head_word;
  lsf_pkg::lsf_word_t          chain [lsf_pkg::TABLE_ENTRIES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ports_q <= lsf_pkg::NUM_PORTS_RST;
    end else if (cfg_we_i) begin
      num_ports_q <= cfg_wdata_i;
    end
  end

  assign hdr_i.ready = adv;

  always_comb begin
    head_word              = '0;
    head_word.vld          = hdr_i.valid;
    head_word.arrival_port = hdr_i.arrival_port;
    head_word.source_host  = hdr_i.source_host;
    head_word.dest_host    = hdr_i.dest_host;
  end

  assign chain[0] = head_word;

  for (genvar i = 0; i < lsf_pkg::TABLE_ENTRIES; i++) begin : g_cell
    lsf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .word_i (chain[i]),
      .word_o (chain[i+1])
    );
  end

  lsf_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (chain[lsf_pkg::TABLE_ENTRIES]),
    .num_ports_i (num_ports_q),
    .adv_o       (adv),
    .res_o       (res_o)
  );

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the learning switch forwarding table against a behavioral
// forwarding table kept inside the bench. Each header word is predicted when
// it is accepted. Each result word is checked field by field against the
// oldest prediction. The run covers directed corner cases, several port
// counts, back-pressure that fills the cell row, and a table filled to
// capacity.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LATENCY     = lsf_pkg::TABLE_ENTRIES + 1;
  localparam int HOLD_CYCLES = 600;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [lsf_pkg::MASK_W-1:0] send_mask;
    logic                       flooded;
    logic                       learned;
    logic                       table_full;
  } fwd_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [lsf_pkg::NPORT_W-1:0] cfg_wdata;

  lsf_hdr_if hdr ();
  lsf_res_if res ();

  learning_switch_forwarding dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .hdr_i       (hdr),
    .res_o       (res)
  );

  always #5 clk = ~clk;

  // forwarding table as the bench sees it
  logic [lsf_pkg::HOST_W-1:0]  host_tbl [lsf_pkg::TABLE_ENTRIES];
  logic [lsf_pkg::PORT_W-1:0]  port_tbl [lsf_pkg::TABLE_ENTRIES];
  int                          fill_cnt = 0;
  logic [lsf_pkg::NPORT_W-1:0] ports_cfg = lsf_pkg::NUM_PORTS_RST;

  fwd_result_t pending_fwd [$];
  int          errors    = 0;
  bit          src_gaps  = 1'b1;
  bit          sink_gaps = 1'b1;
  bit          hold_req  = 1'b0;
  int          hold_cnt  = 0;
  int          stall_cnt = 0;

  function automatic fwd_result_t forward_lookup(
    input logic [lsf_pkg::PORT_W-1:0] arr,
    input logic [lsf_pkg::HOST_W-1:0] src,
    input logic [lsf_pkg::HOST_W-1:0] dst);
    fwd_result_t r;
    int          in_use;
    int          i;
    bit          hit;
    bit          known;
    r      = '0;
    hit    = 1'b0;
    known  = 1'b0;
    in_use = (ports_cfg > lsf_pkg::MAX_PORTS) ? lsf_pkg::MAX_PORTS : int'(ports_cfg);
    for (i = 0; i < fill_cnt; i++) begin
      if (host_tbl[i] == dst) begin
        hit = 1'b1;
        if (port_tbl[i] < in_use) r.send_mask[port_tbl[i]] = 1'b1;
      end
      if (host_tbl[i] == src) known = 1'b1;
    end
    if (!hit) begin
      for (i = 0; i < in_use; i++)
        if (i != arr) r.send_mask[i] = 1'b1;
    end
    r.flooded = !hit;
    if (!known) begin
      if (fill_cnt < lsf_pkg::TABLE_ENTRIES) begin
        host_tbl[fill_cnt] = src;
        port_tbl[fill_cnt] = arr;
        fill_cnt++;
        r.learned = 1'b1;
      end else begin
        r.table_full = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_result();
    fwd_result_t e;
    if (pending_fwd.size() == 0) begin
      report_mismatch($sformatf("unexpected result word, mask %h", res.send_mask));
      return;
    end
    e = pending_fwd.pop_front();
    if (res.send_mask !== e.send_mask)
      report_mismatch($sformatf("send_mask %h, want %h", res.send_mask, e.send_mask));
    if (res.flooded !== e.flooded)
      report_mismatch($sformatf("flooded %b, want %b", res.flooded, e.flooded));
    if (res.learned !== e.learned)
      report_mismatch($sformatf("learned %b, want %b", res.learned, e.learned));
    if (res.table_full !== e.table_full)
      report_mismatch($sformatf("table_full %b, want %b", res.table_full, e.table_full));
  endtask

  // result checking and stall watchdog
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (res.valid && res.ready) check_result();
      if ((hdr.valid && hdr.ready) || (res.valid && res.ready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt > STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // result receiver
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_cnt = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res.ready <= 1'b0;
      end else if (sink_gaps) begin
        res.ready <= ($urandom_range(99) >= 30);
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  task automatic send_header(input logic [lsf_pkg::PORT_W-1:0] arr,
                             input logic [lsf_pkg::HOST_W-1:0] src,
                             input logic [lsf_pkg::HOST_W-1:0] dst);
    if (src_gaps && $urandom_range(99) < 30) begin
      hdr.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    hdr.valid        <= 1'b1;
    hdr.arrival_port <= arr;
    hdr.source_host  <= src;
    hdr.dest_host    <= dst;
    @(posedge clk);
    while (!hdr.ready) @(posedge clk);
    pending_fwd.push_back(forward_lookup(arr, src, dst));
  endtask

  // sources and destinations lean on known hosts so lookups hit and the
  // table fills gradually instead of saturating early
  task automatic send_random();
    logic [lsf_pkg::PORT_W-1:0] arr;
    logic [lsf_pkg::HOST_W-1:0] src;
    logic [lsf_pkg::HOST_W-1:0] dst;
    arr = lsf_pkg::PORT_W'($urandom_range(7));
    if (fill_cnt > 0 && $urandom_range(99) < 70)
      src = host_tbl[$urandom_range(fill_cnt - 1)];
    else
      src = lsf_pkg::HOST_W'($urandom_range(255));
    if (fill_cnt > 0 && $urandom_range(99) < 50)
      dst = host_tbl[$urandom_range(fill_cnt - 1)];
    else
      dst = lsf_pkg::HOST_W'($urandom_range(255));
    send_header(arr, src, dst);
  endtask

  task automatic drain();
    hdr.valid <= 1'b0;
    while (pending_fwd.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_num_ports(input logic [lsf_pkg::NPORT_W-1:0] n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    ports_cfg = n;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    // reset port count of 8
    send_header(3'd0, 8'd0,   8'd0);    // src == dst, both unknown
    send_header(3'd7, 8'd255, 8'd255);
    send_header(3'd3, 8'd10,  8'd0);    // hit on port 0
    send_header(3'd0, 8'd20,  8'd0);    // matched port equals arrival
    send_header(3'd5, 8'd0,   8'd10);   // known source
    write_num_ports(4'd4);
    send_header(3'd6, 8'd30,  8'd255);  // matched port not in use
    send_header(3'd6, 8'd31,  8'd99);   // arrival port not in use
    send_header(3'd2, 8'd32,  8'd10);
    write_num_ports(4'd0);
    send_header(3'd2, 8'd40,  8'd77);   // no ports: flood to nothing
    send_header(3'd2, 8'd41,  8'd10);   // no ports: hit to nothing
    write_num_ports(4'd15);
    send_header(3'd1, 8'd50,  8'd123);  // count clamps to 8
    send_header(3'd4, 8'd51,  8'd255);
    write_num_ports(4'd1);
    send_header(3'd0, 8'd60,  8'd200);
    send_header(3'd3, 8'd61,  8'd200);
    send_header(3'd0, 8'd62,  8'd0);
    write_num_ports(4'd8);
    send_header(3'd7, 8'd170, 8'd85);
    send_header(3'd2, 8'd85,  8'd170);
  endtask

  task automatic test_port_counts();
    logic [lsf_pkg::NPORT_W-1:0] counts [8];
    int                          k;
    int                          n;
    counts = '{4'd8, 4'd1, 4'd2, 4'd5, 4'd0, 4'd15, 4'd3, 4'd7};
    for (k = 0; k < 8; k++) begin
      write_num_ports(k == 7 ? lsf_pkg::NPORT_W'($urandom_range(15)) : counts[k]);
      for (n = 0; n < 110; n++) send_random();
    end
  endtask

  task automatic test_no_idle();
    int n;
    write_num_ports(4'd6);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    for (n = 0; n < 250; n++) send_random();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    int n;
    write_num_ports(4'd8);
    src_gaps = 1'b0;
    hold_req = 1'b1;
    for (n = 0; n < 350; n++) send_random();
    src_gaps = 1'b1;
  endtask

  task automatic test_table_fill();
    int n;
    write_num_ports(4'd8);
    for (n = 0; n < 256; n++)
      send_header(3'($urandom_range(7)), 8'(n), 8'($urandom_range(255)));
    for (n = 0; n < 100; n++) send_random();
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    hdr.valid        <= 1'b0;
    hdr.arrival_port <= '0;
    hdr.source_host  <= '0;
    hdr.dest_host    <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_port_counts();
    test_no_idle();
    test_backpressure();
    test_table_fill();

    drain();
    repeat (LATENCY + 20) @(posedge clk);
    if (pending_fwd.size() != 0) report_mismatch("results still pending at end");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
